// ----- src/bdq_pkg.sv -----
// Shared codes and field widths for the bounded deque unit.
package bdq_pkg;

   localparam int KIND_W   = 3;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 8;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEEK       = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd5;
   localparam logic [KIND_W-1:0] KIND_ROTATE     = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

// ----- src/bdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/bdq_mod.sv -----
// Bit-serial restoring remainder unit: position modulo entry count.
module bdq_mod import bdq_pkg::*; #(
   parameter int CW = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [POS_W-1:0] dividend,
   input  logic [CW-1:0]    divisor,
   output logic             done,
   output logic [CW-1:0]    remainder
);

   localparam int SW = $clog2(POS_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    div_ff, div_in;
   logic [POS_W-1:0] dvd_ff, dvd_in;
   logic [CW:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      trial   = {rem_ff, dvd_ff[POS_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         div_in  = divisor;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in  = trial[CW-1:0];
         dvd_in  = {dvd_ff[POS_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(POS_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/bounded_deque_with_indexed_remove_unit.sv -----
// Bounded deque with peek, remove and remove-and-rotate by position.
// Push: check, plan, front read, back read, back capture, output. Pop, peek, remove and
// rotate add data capture; circular positions add the bit-serial remainder unit; remove
// and rotate add a read and a write state per moved entry through the one RAM port pair.
// One transaction at a time: the next is accepted in the cycle after the result is taken.
// Reset (synchronous) empties the deque, sets the front pointer to 0 and linear mode;
// RAM contents are not cleared.
module bounded_deque_with_indexed_remove_unit import bdq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic         csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // value[31:0], position[39:32]
   input  logic [2:0]   req_tuser,   // kind[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // data_out[31:0], entry_count[36:32],
                                     // front_word[68:37], back_word[100:69]
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_MOD, S_PLAN, S_DATA, S_COPY_RD, S_COPY_WR,
      S_FRONT_RD, S_BACK_RD, S_BACK_CAP, S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic                  circ_ff, circ_in;
   logic [AW-1:0]         fp_ff, fp_in;
   logic [CW-1:0]         n_ff, n_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CW-1:0]         p_ff, p_in;
   logic [AW-1:0]         src_ff, src_in;
   logic [AW-1:0]         dst_ff, dst_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   logic                  mod_start, mod_done;
   logic [CW-1:0]         mod_rem;

   logic [63:0]           data_ext, front_ext, back_ext;
   logic [15:0]           n_ext;

   function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = (CW+1)'(a) + (CW+1)'(b);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] a);
      return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   bdq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bdq_mod #(.CW(CW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (pos_ff),
      .divisor   (n_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in  = state_ff;
      circ_in   = csr_wen ? csr_wdata : circ_ff;
      fp_in     = fp_ff;
      n_in      = n_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      p_in      = p_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = dst_ff;
      ram_wdata = ram_rdata;
      ram_raddr = src_ff;
      mod_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               value_in  = DATA_WIDTH'(req_tdata[31:0]);
               pos_in    = req_tdata[39:32];
               status_in = ST_OK;
               data_in   = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (kind_ff == KIND_PUSH_FRONT || kind_ff == KIND_PUSH_BACK) begin
               if (n_ff == CW'(DEPTH)) begin
                  status_in = ST_FULL;
                  state_in  = S_FRONT_RD;
               end else begin
                  state_in = S_PLAN;
               end
            end else if (kind_ff == KIND_POP_FRONT || kind_ff == KIND_POP_BACK ||
                         kind_ff == KIND_PEEK || kind_ff == KIND_REMOVE ||
                         kind_ff == KIND_ROTATE) begin
               if (n_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = S_FRONT_RD;
               end else if (kind_ff == KIND_POP_FRONT || kind_ff == KIND_POP_BACK) begin
                  state_in = S_PLAN;
               end else if (circ_ff) begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end else if (16'(pos_ff) >= 16'(n_ff)) begin
                  status_in = ST_RANGE;
                  state_in  = S_FRONT_RD;
               end else begin
                  p_in     = CW'(pos_ff);
                  state_in = S_PLAN;
               end
            end else begin
               state_in = S_FRONT_RD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               p_in     = mod_rem;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            cnt_in   = '0;
            state_in = S_DATA;
            case (kind_ff)
               KIND_PUSH_FRONT: begin
                  fp_in     = (fp_ff == '0) ? AW'(DEPTH - 1) : fp_ff - 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = fp_in;
                  ram_wdata = value_ff;
                  n_in      = n_ff + 1'b1;
                  state_in  = S_FRONT_RD;
               end
               KIND_PUSH_BACK: begin
                  ram_we    = 1'b1;
                  ram_waddr = add_mod(fp_ff, n_ff);
                  ram_wdata = value_ff;
                  n_in      = n_ff + 1'b1;
                  state_in  = S_FRONT_RD;
               end
               KIND_POP_FRONT: begin
                  ram_raddr = fp_ff;
                  fp_in     = inc_mod(fp_ff);
                  n_in      = n_ff - 1'b1;
               end
               KIND_POP_BACK: begin
                  ram_raddr = add_mod(fp_ff, n_ff - 1'b1);
                  n_in      = n_ff - 1'b1;
               end
               KIND_PEEK: begin
                  ram_raddr = add_mod(fp_ff, p_ff);
               end
               KIND_REMOVE: begin
                  ram_raddr = add_mod(fp_ff, p_ff);
                  src_in    = add_mod(fp_ff, p_ff + 1'b1);
                  dst_in    = add_mod(fp_ff, p_ff);
                  cnt_in    = n_ff - 1'b1 - p_ff;
                  n_in      = n_ff - 1'b1;
               end
               KIND_ROTATE: begin
                  // entries ahead of the removed one move past the back
                  ram_raddr = add_mod(fp_ff, p_ff);
                  src_in    = fp_ff;
                  dst_in    = add_mod(fp_ff, n_ff);
                  cnt_in    = p_ff;
                  fp_in     = add_mod(fp_ff, p_ff + 1'b1);
                  n_in      = n_ff - 1'b1;
               end
               default: begin
                  state_in = S_FRONT_RD;
               end
            endcase
         end
         S_DATA: begin
            data_in  = ram_rdata;
            state_in = (cnt_ff != '0) ? S_COPY_RD : S_FRONT_RD;
         end
         S_COPY_RD: begin
            ram_raddr = src_ff;
            state_in  = S_COPY_WR;
         end
         S_COPY_WR: begin
            ram_we    = 1'b1;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            src_in    = inc_mod(src_ff);
            dst_in    = inc_mod(dst_ff);
            cnt_in    = cnt_ff - 1'b1;
            state_in  = (cnt_ff == CW'(1)) ? S_FRONT_RD : S_COPY_RD;
         end
         S_FRONT_RD: begin
            if (n_ff == '0) begin
               front_in = '0;
               back_in  = '0;
               state_in = S_OUT;
            end else begin
               ram_raddr = fp_ff;
               state_in  = S_BACK_RD;
            end
         end
         S_BACK_RD: begin
            front_in  = ram_rdata;
            ram_raddr = add_mod(fp_ff, n_ff - 1'b1);
            state_in  = S_BACK_CAP;
         end
         S_BACK_CAP: begin
            back_in  = ram_rdata;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         circ_ff  <= 1'b0;
         fp_ff    <= '0;
         n_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         circ_ff  <= circ_in;
         fp_ff    <= fp_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
      end
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      p_ff      <= p_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      data_ff   <= data_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      status_ff <= status_in;
   end

   assign data_ext  = 64'(data_ff);
   assign front_ext = 64'(front_ff);
   assign back_ext  = 64'(back_ff);
   assign n_ext     = 16'(n_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {3'b000, back_ext[WORD_W-1:0], front_ext[WORD_W-1:0],
                        n_ext[COUNT_W-1:0], data_ext[WORD_W-1:0]};
   assign rsp_tuser  = status_ff;

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(DEPTH))
      else $error("occupancy exceeds depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted a second transaction while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while result pending");

   a_count_stable_in_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(n_ff) && $stable(fp_ff))
      else $error("deque state changed while result pending");

endmodule
